// ===== hw/rtl/char_lcd_bus_sequencer_defines.svh =====
// Assertion macros shared by the character LCD bus sequencer checkers.
`ifndef CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CLBS_CHK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CLBS_CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/clbs_pkg.sv =====
// Shared types, constants and init tables for the character LCD bus sequencer.
package clbs_pkg;

    localparam int unsigned LINE_COLUMNS_DEF = 40;

    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 40;
    localparam int unsigned M_TUSER_W = 1;

    localparam int unsigned BIN_W  = 32;
    localparam int unsigned DIGITS = 10;
    localparam int unsigned BCD_W  = 4 * DIGITS;
    localparam int unsigned DIG_W  = $clog2(DIGITS);
    localparam int unsigned COL_W  = 6;

    localparam logic [16:0] WAIT_POWERUP = 17'd70000;
    localparam logic [10:0] WAIT_LONG    = 11'd2000;
    localparam logic [10:0] WAIT_SHORT   = 11'd100;

    localparam logic [7:0] LINE0_BASE = 8'h80;
    localparam logic [7:0] LINE1_BASE = 8'hC0;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    localparam logic [2:0] INIT_LAST_8 = 3'd4;
    localparam logic [2:0] INIT_LAST_4 = 3'd6;

    typedef enum logic [2:0] {
        OP_INIT    = 3'd0,
        OP_COMMAND = 3'd1,
        OP_CHAR    = 3'd2,
        OP_NUMBER  = 3'd3,
        OP_GOTO    = 3'd4
    } t_op;

    typedef enum logic {
        BUS_8BIT = 1'b0,
        BUS_4BIT = 1'b1
    } t_bus_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SINGLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    // One bus word: a byte request into the strobe stage, or one strobe out of it.
    typedef struct packed {
        logic        rs;
        logic [7:0]  data;
        logic [16:0] wait_before;
        logic [10:0] wait_after;
        logic        last;
    } t_strobe;

    function automatic logic [7:0] init_cmd(input t_bus_mode mode, input logic [2:0] idx);
        logic [7:0] cmd;
        if (mode == BUS_8BIT) begin
            case (idx)
                3'd0:    cmd = 8'h38;
                3'd1:    cmd = 8'h0C;
                3'd2:    cmd = 8'h02;
                3'd3:    cmd = 8'h06;
                default: cmd = 8'h01;
            endcase
        end else begin
            case (idx)
                3'd0:    cmd = 8'h33;
                3'd1:    cmd = 8'h32;
                3'd2:    cmd = 8'h28;
                3'd3:    cmd = 8'h0C;
                3'd4:    cmd = 8'h02;
                3'd5:    cmd = 8'h06;
                default: cmd = 8'h01;
            endcase
        end
        return cmd;
    endfunction

    // Display-on gets the short settle, everything else the long one.
    function automatic logic [10:0] init_wait(input t_bus_mode mode, input logic [2:0] idx);
        logic short_one;
        short_one = (mode == BUS_8BIT) ? (idx == 3'd1) : (idx == 3'd3);
        return short_one ? WAIT_SHORT : WAIT_LONG;
    endfunction

endpackage

// ===== hw/rtl/char_lcd_bus_sequencer.sv =====
// Top level of the character LCD bus sequencer: request decode and byte sequencing.
//
// - Slave channel s_axis_*: one request word per handshake. tuser carries the
//   operation (init, command, character, number, goto); tdata carries the byte,
//   the signed number, the row and the column.
// - Master channel m_axis_*: one word per enable strobe. tuser is the register
//   select, tlast marks the final strobe of a request, tdata carries D7..D0 and
//   the settle times before and after the strobe.
// - Config: i_cfg_we writes i_cfg_wdata into the bus mode (0 = 8-bit, 1 = 4-bit).
//   Write it only while no request is in flight.
// - One request is in flight at a time; s_axis_tready is low from acceptance
//   until the last byte of the request has moved into the strobe stage.
// - Timing: command, character and goto pass through the sequencer state register
//   and the output register before their strobe; init puts out one strobe per cycle
//   while m_axis_tready is high. Number loads a 32-step double-dabble converter, then
//   walks the ten digit places (leading zeros skipped), after a sign if negative.
// - Stalls: the output register holds its word while m_axis_tready is low; the
//   sequencer waits behind it, so no word is lost or repeated.
// - Reset (i_rst_n low, synchronous): sequencer idle, output empty, bus mode
//   back to 4-bit.
module char_lcd_bus_sequencer #(
    parameter int unsigned LINE_COLUMNS = clbs_pkg::LINE_COLUMNS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] byte_value, [39:8] number_value, [40] row, [46:41] column, [47] zero
    input  logic [clbs_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [2:0] operation
    input  logic [clbs_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] bus_data, [24:8] wait_before_ticks, [35:25] wait_after_ticks, [39:36] zero
    output logic [clbs_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // [0] register_select
    output logic [clbs_pkg::M_TUSER_W-1:0]    m_axis_tuser,
    output logic                              m_axis_tlast
);
    import clbs_pkg::*;

    localparam logic [COL_W-1:0] COL_MAX = COL_W'(LINE_COLUMNS - 1);

    // request fields
    logic [2:0]       in_op;
    logic [7:0]       in_byte;
    logic [BIN_W-1:0] in_num;
    logic             in_row;
    logic [COL_W-1:0] in_col;
    logic [COL_W-1:0] col_sat;
    logic [BIN_W-1:0] in_mag;
    logic             in_acc;

    // sequencer state
    t_state           r_state, n_state;
    t_bus_mode        r_mode;
    logic [2:0]       r_idx, n_idx;
    logic [DIG_W-1:0] r_dig, n_dig;
    logic             r_started, n_started;
    logic             r_neg, n_neg;
    t_strobe          r_single, n_single;

    // links to the converter and strobe stage
    logic             bcd_start;
    logic             bcd_done;
    logic [BCD_W-1:0] bcd;
    logic [3:0]       cur_dig;
    logic             req_valid;
    logic             req_ready;
    t_strobe          req;
    logic             out_valid;
    t_strobe          out_strobe;

    assign in_op   = s_axis_tuser[2:0];
    assign in_byte = s_axis_tdata[7:0];
    assign in_num  = s_axis_tdata[39:8];
    assign in_row  = s_axis_tdata[40];
    assign in_col  = s_axis_tdata[46:41];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // columns past the line end stick at the last column
    assign col_sat = (in_col > COL_MAX) ? COL_MAX : in_col;
    // two's complement magnitude; the most negative value maps to 2^31 unsigned
    assign in_mag  = in_num[BIN_W-1] ? (BIN_W'(0) - in_num) : in_num;

    assign bcd_start = in_acc && (in_op == OP_NUMBER);
    assign cur_dig   = bcd[{r_dig, 2'b00} +: 4];

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_dig     = r_dig;
        n_started = r_started;
        n_neg     = r_neg;
        n_single  = r_single;
        req_valid = 1'b0;
        req       = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_single.wait_before = '0;
                    n_single.wait_after  = '0;
                    n_single.last        = 1'b1;
                    n_single.data        = in_byte;
                    n_single.rs          = 1'b0;
                    n_idx                = '0;
                    n_neg                = in_num[BIN_W-1];
                    case (in_op)
                        OP_INIT:    n_state = ST_INIT;
                        OP_COMMAND: n_state = ST_SINGLE;
                        OP_CHAR: begin
                            n_single.rs = 1'b1;
                            n_state     = ST_SINGLE;
                        end
                        OP_NUMBER:  n_state = ST_CONV;
                        OP_GOTO: begin
                            n_single.data = (in_row ? LINE1_BASE : LINE0_BASE)
                                          + {2'b00, col_sat};
                            n_state       = ST_SINGLE;
                        end
                        default:    n_state = ST_IDLE;   // unknown op: dropped
                    endcase
                end
            end

            ST_INIT: begin
                req_valid       = 1'b1;
                req.rs          = 1'b0;
                req.data        = init_cmd(r_mode, r_idx);
                req.wait_before = (r_idx == 3'd0) ? WAIT_POWERUP : 17'd0;
                req.wait_after  = init_wait(r_mode, r_idx);
                req.last        = (r_mode == BUS_8BIT) ? (r_idx == INIT_LAST_8)
                                                       : (r_idx == INIT_LAST_4);
                if (req_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (req.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end

            ST_SINGLE: begin
                req_valid = 1'b1;
                req       = r_single;
                if (req_ready) begin
                    n_state = ST_IDLE;
                end
            end

            ST_CONV: begin
                n_dig     = DIG_W'(DIGITS - 1);
                n_started = 1'b0;
                if (bcd_done) begin
                    n_state = r_neg ? ST_SIGN : ST_DIGIT;
                end
            end

            ST_SIGN: begin
                req_valid = 1'b1;
                req.rs    = 1'b1;
                req.data  = CHAR_MINUS;
                if (req_ready) begin
                    n_state = ST_DIGIT;
                end
            end

            ST_DIGIT: begin
                // leading zeros are skipped, the units digit always prints
                if (cur_dig == 4'd0 && !r_started && r_dig != '0) begin
                    n_dig = r_dig - 1'b1;
                end else begin
                    req_valid = 1'b1;
                    req.rs    = 1'b1;
                    req.data  = CHAR_ZERO + {4'h0, cur_dig};
                    req.last  = (r_dig == '0);
                    if (req_ready) begin
                        n_started = 1'b1;
                        if (r_dig == '0) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_dig = r_dig - 1'b1;
                        end
                    end
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= BUS_4BIT;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mode <= t_bus_mode'(i_cfg_wdata);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_dig     <= n_dig;
        r_started <= n_started;
        r_neg     <= n_neg;
        r_single  <= n_single;
    end

    clbs_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bcd_start),
        .i_bin   (in_mag),
        .o_done  (bcd_done),
        .o_bcd   (bcd)
    );

    clbs_strobe u_strobe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_ready (req_ready),
        .o_valid     (out_valid),
        .o_strobe    (out_strobe),
        .i_ready     (m_axis_tready)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {4'h0, out_strobe.wait_after, out_strobe.wait_before,
                            out_strobe.data};
    assign m_axis_tuser  = out_strobe.rs;
    assign m_axis_tlast  = out_strobe.last;

endmodule

// ===== hw/rtl/clbs_bcd.sv =====
// Iterative binary to BCD converter: one shift-and-adjust step per cycle.
module clbs_bcd (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [clbs_pkg::BIN_W-1:0]    i_bin,
    output logic                          o_done,
    output logic [clbs_pkg::BCD_W-1:0]    o_bcd
);
    import clbs_pkg::*;

    localparam int unsigned CNT_W = $clog2(BIN_W);

    logic [BIN_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [BCD_W-1:0] adj;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic             cnt_end;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                      : r_bcd[4*d +: 4];
        end
    end

    assign cnt_end = (r_cnt == CNT_W'(BIN_W - 1));

    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_bin  = i_bin;
            n_bcd  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd = {adj[BCD_W-2:0], r_bin[BIN_W-1]};
            n_bin = {r_bin[BIN_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (cnt_end) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

// ===== hw/rtl/clbs_strobe.sv =====
// Strobe stage: splits bytes into nibbles in 4-bit mode, holds the output word.
module clbs_strobe (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  clbs_pkg::t_bus_mode    i_mode,
    input  logic                   i_req_valid,
    input  clbs_pkg::t_strobe      i_req,
    output logic                   o_req_ready,
    output logic                   o_valid,
    output clbs_pkg::t_strobe      o_strobe,
    input  logic                   i_ready
);
    import clbs_pkg::*;

    logic    r_valid, n_valid;
    logic    r_pend, n_pend;
    t_strobe r_out, n_out;
    t_strobe r_lo, n_lo;
    logic    out_free;

    assign out_free    = !r_valid || i_ready;
    assign o_req_ready = out_free && !r_pend;

    always_comb begin
        n_valid = r_valid;
        n_pend  = r_pend;
        n_out   = r_out;
        n_lo    = r_lo;
        if (out_free) begin
            n_valid = 1'b0;
            if (r_pend) begin
                n_out   = r_lo;
                n_valid = 1'b1;
                n_pend  = 1'b0;
            end else if (i_req_valid) begin
                n_valid = 1'b1;
                if (i_mode == BUS_8BIT) begin
                    n_out = i_req;
                end else begin
                    // high nibble now, low nibble held for the next word
                    n_out.rs          = i_req.rs;
                    n_out.data        = {i_req.data[7:4], 4'h0};
                    n_out.wait_before = i_req.wait_before;
                    n_out.wait_after  = '0;
                    n_out.last        = 1'b0;
                    n_lo.rs           = i_req.rs;
                    n_lo.data         = {i_req.data[3:0], 4'h0};
                    n_lo.wait_before  = '0;
                    n_lo.wait_after   = i_req.wait_after;
                    n_lo.last         = i_req.last;
                    n_pend            = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_lo  <= n_lo;
    end

    assign o_valid  = r_valid;
    assign o_strobe = r_out;

endmodule

// ===== hw/rtl/clbs_checker.sv =====
// Port-level checker for the character LCD bus sequencer, bound to the top level.
`include "char_lcd_bus_sequencer_defines.svh"

module clbs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [clbs_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input logic [clbs_pkg::M_TUSER_W-1:0]    m_axis_tuser,
    input logic                              m_axis_tlast
);
    import clbs_pkg::*;

    logic [M_TDATA_W+M_TUSER_W:0] out_word;
    logic [16:0]                  wait_before;
    logic [10:0]                  wait_after;
    logic                         out_stall;
    logic                         pre_wait_seen;
    logic                         pre_wait_ok;
    logic                         post_wait_seen;

    assign out_word       = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
    assign wait_before    = m_axis_tdata[24:8];
    assign wait_after     = m_axis_tdata[35:25];
    assign out_stall      = m_axis_tvalid && !m_axis_tready;
    assign pre_wait_seen  = m_axis_tvalid && (wait_before != '0);
    assign pre_wait_ok    = (wait_before == WAIT_POWERUP) && !m_axis_tuser[0] && !m_axis_tlast;
    assign post_wait_seen = m_axis_tvalid && (wait_after != '0);

    // stalled output word holds
    `CLBS_CHK_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "stalled word changed")

    // output register comes out of reset empty
    `CLBS_CHK_NOW(a_reset_empty, !$past(i_rst_n), !m_axis_tvalid, "valid out of reset")

    // only the first init strobe carries a pre-wait, and it is the power-up wait
    `CLBS_CHK_NOW(a_powerup_wait, pre_wait_seen, pre_wait_ok, "bad pre-strobe wait")

    // post-wait only on command-register strobes
    `CLBS_CHK_NOW(a_post_wait_rs, post_wait_seen, !m_axis_tuser[0], "post-wait on a data strobe")

endmodule

bind char_lcd_bus_sequencer clbs_checker u_clbs_checker (.*);
